FILE: hdl/pdsc_pkg.sv
// Package with the types, constants and codes shared by the deframer files.
package pdsc_pkg;

    localparam int unsigned MAX_PAYLOAD = 1018;
    localparam int unsigned LEN_W       = 16;
    localparam int unsigned CNT_W       = 10;
    localparam int unsigned WAIT_W      = 17;
    localparam int unsigned ADDR_W      = 3;
    localparam int unsigned DATA_W      = 32;

    localparam logic [7:0]        SYNC_BYTE   = 8'h3D;
    localparam logic [3:0]        NIBBLE_MASK = 4'hF;
    localparam logic [LEN_W-1:0]  LEN_MIN     = LEN_W'(2);
    localparam logic [LEN_W-1:0]  LEN_MAX     = LEN_W'(MAX_PAYLOAD + 2);

    localparam logic [15:0] HEADER_TIMEOUT_RESET = 16'd200;
    localparam logic [7:0]  BODY_TIMEOUT_RESET   = 8'd100;

    localparam logic REG_HEADER_TIMEOUT = 1'b0;
    localparam logic REG_BODY_TIMEOUT   = 1'b1;

    localparam logic REQ_BYTE = 1'b0;
    localparam logic REQ_TICK = 1'b1;

    localparam logic KIND_PAYLOAD = 1'b0;
    localparam logic KIND_REPORT  = 1'b1;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_LENGTH   = 2'd1;
    localparam logic [1:0] ST_TIMEOUT  = 2'd2;
    localparam logic [1:0] ST_CHECKSUM = 2'd3;

    typedef enum logic [6:0] {
        PH_HUNT    = 7'b0000001,
        PH_LEN_HI  = 7'b0000010,
        PH_LEN_LO  = 7'b0000100,
        PH_CODE    = 7'b0001000,
        PH_SUB     = 7'b0010000,
        PH_PAYLOAD = 7'b0100000,
        PH_CHECK   = 7'b1000000
    } phase_t;

    typedef struct packed {
        logic       req_type;
        logic [7:0] rx_byte;
    } in_item_t;

    typedef struct packed {
        logic             result_kind;
        logic [7:0]       data_byte;
        logic [CNT_W-1:0] byte_index;
        logic [3:0]       command_nibble;
        logic [7:0]       data_code;
        logic [7:0]       sub_code;
        logic [CNT_W-1:0] payload_count;
        logic [1:0]       frame_status;
    } out_item_t;

    typedef struct packed {
        logic [15:0] header_timeout;
        logic [7:0]  body_timeout;
    } cfg_t;

endpackage

FILE: hdl/pdsc_regs.sv
// APB-style configuration registers for the deframer timeouts.
module pdsc_regs (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [pdsc_pkg::ADDR_W-1:0] paddr,
    input  logic [pdsc_pkg::DATA_W-1:0] pwdata,
    output logic [pdsc_pkg::DATA_W-1:0] prdata,
    output logic                        pready,
    output pdsc_pkg::cfg_t              cfg
);

    logic        wr_en;
    logic        reg_sel;
    logic [15:0] header_timeout_reg;
    logic [7:0]  body_timeout_reg;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite && pready;
    assign reg_sel = paddr[2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            header_timeout_reg <= pdsc_pkg::HEADER_TIMEOUT_RESET;
            body_timeout_reg   <= pdsc_pkg::BODY_TIMEOUT_RESET;
        end
        else if (wr_en)
        begin
            case (reg_sel)
                pdsc_pkg::REG_HEADER_TIMEOUT: header_timeout_reg <= pwdata[15:0];
                pdsc_pkg::REG_BODY_TIMEOUT:   body_timeout_reg   <= pwdata[7:0];
                default:                      header_timeout_reg <= header_timeout_reg;
            endcase
        end
    end

    always_comb
    begin
        case (reg_sel)
            pdsc_pkg::REG_HEADER_TIMEOUT: prdata = {16'd0, header_timeout_reg};
            pdsc_pkg::REG_BODY_TIMEOUT:   prdata = {24'd0, body_timeout_reg};
            default:                      prdata = '0;
        endcase
    end

    assign cfg.header_timeout = header_timeout_reg;
    assign cfg.body_timeout   = body_timeout_reg;

endmodule

FILE: hdl/pdsc_core.sv
// Deframer state machine with the result output register.
module pdsc_core (
    input  logic                clk,
    input  logic                rst_n,
    input  pdsc_pkg::cfg_t      cfg,
    input  logic                in_valid,
    output logic                in_ready,
    input  pdsc_pkg::in_item_t  in_item,
    output logic                out_valid,
    input  logic                out_ready,
    output pdsc_pkg::out_item_t out_item
);

    localparam int unsigned CW = pdsc_pkg::CNT_W;
    localparam int unsigned WW = pdsc_pkg::WAIT_W;

    pdsc_pkg::phase_t    phase_reg, phase_next;
    logic [7:0]          length_high_reg, length_high_next;
    logic [CW-1:0]       payload_length_reg, payload_length_next;
    logic [CW-1:0]       byte_count_reg, byte_count_next;
    logic [7:0]          running_sum_reg, running_sum_next;
    logic [7:0]          data_code_reg, data_code_next;
    logic [7:0]          sub_code_reg, sub_code_next;
    logic [WW-1:0]       wait_ticks_reg, wait_ticks_next;
    logic                out_valid_reg, out_valid_next;
    pdsc_pkg::out_item_t out_item_reg, out_item_next;

    logic                in_fire;
    logic                emit;
    pdsc_pkg::out_item_t res;
    logic [WW-1:0]       wait_inc;
    logic [15:0]         len;
    logic [CW:0]         count_inc;
    logic [7:0]          b;

    assign in_ready  = !out_valid_reg || out_ready;
    assign in_fire   = in_valid && in_ready;
    assign b         = in_item.rx_byte;
    assign wait_inc  = wait_ticks_reg + WW'(1);
    assign len       = {length_high_reg, b};
    assign count_inc = {1'b0, byte_count_reg} + (CW+1)'(1);

    always_comb
    begin
        phase_next          = phase_reg;
        length_high_next    = length_high_reg;
        payload_length_next = payload_length_reg;
        byte_count_next     = byte_count_reg;
        running_sum_next    = running_sum_reg;
        data_code_next      = data_code_reg;
        sub_code_next       = sub_code_reg;
        wait_ticks_next     = wait_ticks_reg;
        emit                = 1'b0;

        res.result_kind    = pdsc_pkg::KIND_REPORT;
        res.data_byte      = 8'd0;
        res.byte_index     = '0;
        res.command_nibble = data_code_reg[3:0] & pdsc_pkg::NIBBLE_MASK;
        res.data_code      = data_code_reg;
        res.sub_code       = sub_code_reg;
        res.payload_count  = payload_length_reg;
        res.frame_status   = pdsc_pkg::ST_OK;

        if (in_item.req_type == pdsc_pkg::REQ_TICK)
        begin
            case (phase_reg)
                pdsc_pkg::PH_LEN_HI, pdsc_pkg::PH_LEN_LO:
                begin
                    wait_ticks_next = wait_inc;
                    if (wait_inc > {1'b0, cfg.header_timeout})
                    begin
                        emit              = 1'b1;
                        res.payload_count = '0;
                        res.frame_status  = pdsc_pkg::ST_TIMEOUT;
                        phase_next        = pdsc_pkg::PH_HUNT;
                    end
                end
                pdsc_pkg::PH_CODE, pdsc_pkg::PH_SUB, pdsc_pkg::PH_PAYLOAD,
                pdsc_pkg::PH_CHECK:
                begin
                    wait_ticks_next = wait_inc;
                    if (wait_inc > {9'd0, cfg.body_timeout})
                    begin
                        emit             = 1'b1;
                        res.frame_status = pdsc_pkg::ST_TIMEOUT;
                        phase_next       = pdsc_pkg::PH_HUNT;
                    end
                end
                default:
                begin
                    phase_next = pdsc_pkg::PH_HUNT;
                end
            endcase
        end
        else
        begin
            case (phase_reg)
                pdsc_pkg::PH_LEN_HI:
                begin
                    length_high_next = b;
                    phase_next       = pdsc_pkg::PH_LEN_LO;
                end
                pdsc_pkg::PH_LEN_LO:
                begin
                    if (len < pdsc_pkg::LEN_MIN || len > pdsc_pkg::LEN_MAX)
                    begin
                        emit              = 1'b1;
                        res.payload_count = '0;
                        res.frame_status  = pdsc_pkg::ST_LENGTH;
                        phase_next        = pdsc_pkg::PH_HUNT;
                    end
                    else
                    begin
                        payload_length_next = CW'(len - pdsc_pkg::LEN_MIN);
                        running_sum_next    = length_high_reg + b;
                        wait_ticks_next     = '0;
                        phase_next          = pdsc_pkg::PH_CODE;
                    end
                end
                pdsc_pkg::PH_CODE:
                begin
                    data_code_next   = b;
                    running_sum_next = running_sum_reg + b;
                    phase_next       = pdsc_pkg::PH_SUB;
                end
                pdsc_pkg::PH_SUB:
                begin
                    sub_code_next    = b;
                    running_sum_next = running_sum_reg + b;
                    byte_count_next  = '0;
                    phase_next       = (payload_length_reg != '0) ? pdsc_pkg::PH_PAYLOAD
                                                                  : pdsc_pkg::PH_CHECK;
                end
                pdsc_pkg::PH_PAYLOAD:
                begin
                    emit             = 1'b1;
                    res.result_kind  = pdsc_pkg::KIND_PAYLOAD;
                    res.data_byte    = b;
                    res.byte_index   = byte_count_reg;
                    running_sum_next = running_sum_reg + b;
                    byte_count_next  = count_inc[CW-1:0];
                    if (count_inc >= {1'b0, payload_length_reg})
                    begin
                        phase_next = pdsc_pkg::PH_CHECK;
                    end
                end
                pdsc_pkg::PH_CHECK:
                begin
                    emit             = 1'b1;
                    res.frame_status = (b == running_sum_reg) ? pdsc_pkg::ST_OK
                                                              : pdsc_pkg::ST_CHECKSUM;
                    phase_next       = pdsc_pkg::PH_HUNT;
                end
                default:
                begin
                    phase_next = pdsc_pkg::PH_HUNT;
                    if (b == pdsc_pkg::SYNC_BYTE)
                    begin
                        phase_next          = pdsc_pkg::PH_LEN_HI;
                        wait_ticks_next     = '0;
                        data_code_next      = 8'd0;
                        sub_code_next       = 8'd0;
                        payload_length_next = '0;
                        byte_count_next     = '0;
                        running_sum_next    = 8'd0;
                    end
                end
            endcase
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg && !out_ready;
        out_item_next  = out_item_reg;
        if (in_fire && emit)
        begin
            out_valid_next = 1'b1;
            out_item_next  = res;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg          <= pdsc_pkg::PH_HUNT;
            length_high_reg    <= 8'd0;
            payload_length_reg <= '0;
            byte_count_reg     <= '0;
            running_sum_reg    <= 8'd0;
            data_code_reg      <= 8'd0;
            sub_code_reg       <= 8'd0;
            wait_ticks_reg     <= '0;
            out_valid_reg      <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (in_fire)
            begin
                phase_reg          <= phase_next;
                length_high_reg    <= length_high_next;
                payload_length_reg <= payload_length_next;
                byte_count_reg     <= byte_count_next;
                running_sum_reg    <= running_sum_next;
                data_code_reg      <= data_code_next;
                sub_code_reg       <= sub_code_next;
                wait_ticks_reg     <= wait_ticks_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        out_item_reg <= out_item_next;
    end

    assign out_valid = out_valid_reg;
    assign out_item  = out_item_reg;

    a_payload_index: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == pdsc_pkg::PH_PAYLOAD |-> byte_count_reg < payload_length_reg)
        else $error("payload index reached payload length");

    a_length_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == pdsc_pkg::PH_CODE || phase_reg == pdsc_pkg::PH_SUB ||
         phase_reg == pdsc_pkg::PH_PAYLOAD || phase_reg == pdsc_pkg::PH_CHECK)
        |-> payload_length_reg <= CW'(pdsc_pkg::MAX_PAYLOAD))
        else $error("accepted payload length out of range");

    a_hunt_tick: assert property (@(posedge clk) disable iff (!rst_n)
        in_fire && in_item.req_type == pdsc_pkg::REQ_TICK && phase_reg == pdsc_pkg::PH_HUNT
        |=> phase_reg == pdsc_pkg::PH_HUNT && out_valid_reg == $past(out_valid_next))
        else $error("tick while hunting changed state");

    a_payload_result: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_item_reg.result_kind == pdsc_pkg::KIND_PAYLOAD
        |-> out_item_reg.frame_status == pdsc_pkg::ST_OK &&
            out_item_reg.byte_index < out_item_reg.payload_count)
        else $error("malformed payload transaction");

endmodule

FILE: hdl/packet_deframer_sum_checksum_top.sv
// Top level of the sync, length and checksum packet deframer.
//
//   port group   direction  handshake              payload
//   in_*         in         in_valid / in_ready    in_item  (pdsc_pkg::in_item_t)
//   out_*        out        out_valid / out_ready  out_item (pdsc_pkg::out_item_t)
//   p*           in/out     psel, penable, pready  paddr, pwdata, prdata
//
// One input per cycle while in_ready is high; any result is valid in the next cycle.
// The deframer state machine and its output register set the rate: one pass per item.
// A result held by out_ready low stalls input only while the output register is full.
// Reset clears the state machine, the output valid and loads the timeout defaults.
module packet_deframer_sum_checksum_top (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  pdsc_pkg::in_item_t          in_item,
    output logic                        out_valid,
    input  logic                        out_ready,
    output pdsc_pkg::out_item_t         out_item,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [pdsc_pkg::ADDR_W-1:0] paddr,
    input  logic [pdsc_pkg::DATA_W-1:0] pwdata,
    output logic [pdsc_pkg::DATA_W-1:0] prdata,
    output logic                        pready
);

    pdsc_pkg::cfg_t cfg;

    pdsc_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    pdsc_core u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_item   (in_item),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_item  (out_item)
    );

endmodule

FILE: dv/tb_top.sv
// Testbench for the sync, length and checksum packet deframer with a built-in frame predictor.
`timescale 1ns / 100ps

module tb_top;

    localparam int unsigned CYCLE_LIMIT = 1_500_000;

    logic                          clk;
    logic                          rst_n    = 1'b0;
    logic                          in_valid = 1'b0;
    logic                          in_ready;
    pdsc_pkg::in_item_t            in_item  = '0;
    logic                          out_valid;
    logic                          out_ready = 1'b0;
    pdsc_pkg::out_item_t           out_item;
    logic                          psel    = 1'b0;
    logic                          penable = 1'b0;
    logic                          pwrite  = 1'b0;
    logic [pdsc_pkg::ADDR_W-1:0]   paddr   = '0;
    logic [pdsc_pkg::DATA_W-1:0]   pwdata  = '0;
    logic [pdsc_pkg::DATA_W-1:0]   prdata;
    logic                          pready;

    pdsc_pkg::out_item_t           deframer_out_q[$];
    int unsigned                   items_accepted = 0;
    int unsigned                   fail_count = 0;
    int unsigned                   cycle_count = 0;
    bit                            idle_on = 1'b1;
    int                            stall_left = 0;

    pdsc_pkg::phase_t              cur_phase = pdsc_pkg::PH_HUNT;
    logic [7:0]                    len_high_byte = '0;
    logic [pdsc_pkg::CNT_W-1:0]    frame_len = '0;
    logic [pdsc_pkg::CNT_W-1:0]    payload_idx = '0;
    logic [7:0]                    csum_acc = '0;
    logic [7:0]                    frame_code = '0;
    logic [7:0]                    frame_sub = '0;
    logic [pdsc_pkg::WAIT_W-1:0]   tick_count = '0;
    logic [15:0]                   header_limit = pdsc_pkg::HEADER_TIMEOUT_RESET;
    logic [7:0]                    body_limit = pdsc_pkg::BODY_TIMEOUT_RESET;

    packet_deframer_sum_checksum_top dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_item   (in_item),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_item  (out_item),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    function automatic pdsc_pkg::out_item_t make_result(logic kind, logic [7:0] data,
                                                        logic [pdsc_pkg::CNT_W-1:0] idx,
                                                        logic [pdsc_pkg::CNT_W-1:0] cnt,
                                                        logic [1:0] status);
        pdsc_pkg::out_item_t r;
        r.result_kind    = kind;
        r.data_byte      = data;
        r.byte_index     = idx;
        r.command_nibble = frame_code[3:0] & pdsc_pkg::NIBBLE_MASK;
        r.data_code      = frame_code;
        r.sub_code       = frame_sub;
        r.payload_count  = cnt;
        r.frame_status   = status;
        return r;
    endfunction

    task automatic advance_deframer(input pdsc_pkg::in_item_t it);
        logic [15:0] len;
        len = {len_high_byte, it.rx_byte};
        if (it.req_type == pdsc_pkg::REQ_TICK)
        begin
            if (cur_phase != pdsc_pkg::PH_HUNT)
            begin
                tick_count = tick_count + 1'b1;
                if (cur_phase == pdsc_pkg::PH_LEN_HI || cur_phase == pdsc_pkg::PH_LEN_LO)
                begin
                    if (tick_count > header_limit)
                    begin
                        deframer_out_q.push_back(make_result(pdsc_pkg::KIND_REPORT, '0, '0, '0,
                                                             pdsc_pkg::ST_TIMEOUT));
                        cur_phase = pdsc_pkg::PH_HUNT;
                    end
                end
                else if (tick_count > body_limit)
                begin
                    deframer_out_q.push_back(make_result(pdsc_pkg::KIND_REPORT, '0, '0,
                                                         frame_len, pdsc_pkg::ST_TIMEOUT));
                    cur_phase = pdsc_pkg::PH_HUNT;
                end
            end
        end
        else
        begin
            case (cur_phase)
                pdsc_pkg::PH_HUNT:
                begin
                    if (it.rx_byte == pdsc_pkg::SYNC_BYTE)
                    begin
                        cur_phase   = pdsc_pkg::PH_LEN_HI;
                        tick_count  = '0;
                        frame_code  = '0;
                        frame_sub   = '0;
                        frame_len   = '0;
                        payload_idx = '0;
                        csum_acc    = '0;
                    end
                end
                pdsc_pkg::PH_LEN_HI:
                begin
                    len_high_byte = it.rx_byte;
                    cur_phase     = pdsc_pkg::PH_LEN_LO;
                end
                pdsc_pkg::PH_LEN_LO:
                begin
                    if (len < pdsc_pkg::LEN_MIN || len > pdsc_pkg::LEN_MAX)
                    begin
                        deframer_out_q.push_back(make_result(pdsc_pkg::KIND_REPORT, '0, '0, '0,
                                                             pdsc_pkg::ST_LENGTH));
                        cur_phase = pdsc_pkg::PH_HUNT;
                    end
                    else
                    begin
                        frame_len  = pdsc_pkg::CNT_W'(len - pdsc_pkg::LEN_MIN);
                        csum_acc   = len_high_byte + it.rx_byte;
                        tick_count = '0;
                        cur_phase  = pdsc_pkg::PH_CODE;
                    end
                end
                pdsc_pkg::PH_CODE:
                begin
                    frame_code = it.rx_byte;
                    csum_acc   = csum_acc + it.rx_byte;
                    cur_phase  = pdsc_pkg::PH_SUB;
                end
                pdsc_pkg::PH_SUB:
                begin
                    frame_sub   = it.rx_byte;
                    csum_acc    = csum_acc + it.rx_byte;
                    payload_idx = '0;
                    cur_phase   = (frame_len != 0) ? pdsc_pkg::PH_PAYLOAD : pdsc_pkg::PH_CHECK;
                end
                pdsc_pkg::PH_PAYLOAD:
                begin
                    deframer_out_q.push_back(make_result(pdsc_pkg::KIND_PAYLOAD, it.rx_byte,
                                                         payload_idx, frame_len,
                                                         pdsc_pkg::ST_OK));
                    csum_acc    = csum_acc + it.rx_byte;
                    payload_idx = payload_idx + 1'b1;
                    if (payload_idx >= frame_len)
                        cur_phase = pdsc_pkg::PH_CHECK;
                end
                default:
                begin
                    deframer_out_q.push_back(make_result(pdsc_pkg::KIND_REPORT, '0, '0,
                        frame_len, (it.rx_byte == csum_acc) ? pdsc_pkg::ST_OK
                                                            : pdsc_pkg::ST_CHECKSUM));
                    cur_phase = pdsc_pkg::PH_HUNT;
                end
            endcase
        end
    endtask

    function automatic void check_field(string name, logic [15:0] want, logic [15:0] got);
        if (got !== want)
        begin
            $error("%s mismatch: expected %0h, actual %0h", name, want, got);
            fail_count++;
        end
    endfunction

    task automatic compare_result(input pdsc_pkg::out_item_t want,
                                  input pdsc_pkg::out_item_t got);
        check_field("result_kind", want.result_kind, got.result_kind);
        check_field("data_byte", want.data_byte, got.data_byte);
        check_field("byte_index", want.byte_index, got.byte_index);
        check_field("command_nibble", want.command_nibble, got.command_nibble);
        check_field("data_code", want.data_code, got.data_code);
        check_field("sub_code", want.sub_code, got.sub_code);
        check_field("payload_count", want.payload_count, got.payload_count);
        check_field("frame_status", want.frame_status, got.frame_status);
    endtask

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && out_ready)
            begin
                if (deframer_out_q.size() == 0)
                begin
                    $error("result with none expected: %p", out_item);
                    fail_count++;
                end
                else
                    compare_result(deframer_out_q.pop_front(), out_item);
            end
            if (in_valid && in_ready)
            begin
                advance_deframer(in_item);
                items_accepted++;
            end
        end
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (!idle_on || r < 60)
            return 0;
        if (r < 93)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    always @(negedge clk)
    begin
        if (stall_left > 0)
        begin
            stall_left <= stall_left - 1;
            out_ready  <= 1'b0;
        end
        else if (idle_on && $urandom_range(0, 99) < 20)
        begin
            stall_left <= pick_gap();
            out_ready  <= 1'b0;
        end
        else
            out_ready <= 1'b1;
    end

    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $error("watchdog expired after %0d cycles", cycle_count);
        $display("Test completed with failures");
        $finish;
    end

    // Call at a falling edge; returns at a falling edge with valid possibly still high.
    task automatic send_item(input pdsc_pkg::in_item_t item);
        int gap;
        in_item  <= item;
        in_valid <= 1'b1;
        do @(posedge clk); while (!in_ready);
        @(negedge clk);
        gap = pick_gap();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
    endtask

    task automatic send_byte(input logic [7:0] b);
        send_item('{req_type: pdsc_pkg::REQ_BYTE, rx_byte: b});
    endtask

    task automatic send_tick();
        send_item('{req_type: pdsc_pkg::REQ_TICK, rx_byte: 8'($urandom)});
    endtask

    task automatic wait_results_drained();
        in_valid <= 1'b0;
        while (deframer_out_q.size() != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    task automatic apb_write(input logic idx, input logic [pdsc_pkg::DATA_W-1:0] value);
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        pwrite  <= 1'b1;
        psel    <= 1'b1;
        penable <= 1'b0;
        @(negedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(negedge clk);
    endtask

    task automatic set_timeouts(input logic [15:0] hdr, input logic [7:0] body);
        wait_results_drained();
        apb_write(pdsc_pkg::REG_HEADER_TIMEOUT, pdsc_pkg::DATA_W'(hdr));
        apb_write(pdsc_pkg::REG_BODY_TIMEOUT, pdsc_pkg::DATA_W'(body));
        header_limit = hdr;
        body_limit   = body;
    endtask

    // Build sync, length and, if legal, codes, payload, checksum; stop at cut_at if >= 0.
    task automatic send_frame(input logic [15:0] len_field, input bit corrupt,
                              input int cut_at, input int tick_pct);
        logic [7:0] frame_bytes[$];
        logic [7:0] csum;
        logic [7:0] b;
        frame_bytes.push_back(pdsc_pkg::SYNC_BYTE);
        frame_bytes.push_back(len_field[15:8]);
        frame_bytes.push_back(len_field[7:0]);
        csum = len_field[15:8] + len_field[7:0];
        if (len_field >= pdsc_pkg::LEN_MIN && len_field <= pdsc_pkg::LEN_MAX)
        begin
            for (int i = 0; i < int'(len_field); i++)
            begin
                b = 8'($urandom);
                frame_bytes.push_back(b);
                csum = csum + b;
            end
            frame_bytes.push_back(corrupt ? (csum ^ 8'($urandom_range(1, 255))) : csum);
        end
        for (int i = 0; i < frame_bytes.size() && i != cut_at; i++)
        begin
            if ($urandom_range(0, 99) < tick_pct)
                send_tick();
            send_byte(frame_bytes[i]);
        end
    endtask

    task automatic test_directed_frames();
        send_tick();
        send_byte(8'h00);
        send_byte(8'hFF);
        send_byte(pdsc_pkg::SYNC_BYTE);
        send_byte(8'h00);
        send_byte(8'h02);
        send_byte(8'hFF);
        send_byte(8'h00);
        send_byte(8'h01);
        send_frame(16'h0000, 1'b0, -1, 0);
        send_frame(16'h0001, 1'b0, -1, 0);
        send_frame(16'hFFFF, 1'b0, -1, 0);
        send_frame(pdsc_pkg::LEN_MAX + 16'd1, 1'b0, -1, 0);
        send_frame(16'h0004, 1'b1, -1, 0);
    endtask

    task automatic test_timeouts();
        set_timeouts(16'h0000, 8'h00);
        send_byte(pdsc_pkg::SYNC_BYTE);
        send_tick();
        send_byte(pdsc_pkg::SYNC_BYTE);
        send_byte(8'h00);
        send_tick();
        send_byte(pdsc_pkg::SYNC_BYTE);
        send_byte(8'h00);
        send_byte(8'h05);
        send_byte(8'hA7);
        send_tick();
        send_byte(pdsc_pkg::SYNC_BYTE);
        send_byte(8'h00);
        send_byte(8'h03);
        send_byte(8'h5C);
        send_byte(8'hC3);
        send_byte(8'h81);
        send_tick();
        set_timeouts(16'd3, 8'hFF);
        send_byte(pdsc_pkg::SYNC_BYTE);
        repeat (3) send_tick();
        send_byte(8'h00);
        send_byte(8'h02);
        send_byte(8'h3E);
        repeat (256) send_tick();
    endtask

    task automatic test_header_timeout_wide();
        set_timeouts(16'd300, pdsc_pkg::BODY_TIMEOUT_RESET);
        idle_on = 1'b0;
        send_byte(pdsc_pkg::SYNC_BYTE);
        repeat (301) send_tick();
        wait_results_drained();
        idle_on = 1'b1;
    endtask

    task automatic test_max_payload();
        set_timeouts(pdsc_pkg::HEADER_TIMEOUT_RESET, pdsc_pkg::BODY_TIMEOUT_RESET);
        send_frame(pdsc_pkg::LEN_MAX, 1'b0, -1, 1);
    endtask

    task automatic send_random_burst();
        int r;
        int k;
        logic [15:0] len;
        r = $urandom_range(0, 99);
        if (r < 68)
        begin
            if ($urandom_range(0, 19) == 0)
                len = 16'($urandom_range(2, 200));
            else
                len = 16'($urandom_range(2, 22));
            send_frame(len, $urandom_range(0, 6) == 0, -1, 6);
        end
        else if (r < 78)
        begin
            case ($urandom_range(0, 3))
                0:       len = 16'h0000;
                1:       len = 16'h0001;
                2:       len = pdsc_pkg::LEN_MAX + 16'd1;
                default: len = 16'($urandom_range(int'(pdsc_pkg::LEN_MAX) + 1, 65535));
            endcase
            send_frame(len, 1'b0, -1, 6);
        end
        else if (r < 88)
        begin
            len = 16'($urandom_range(2, 22));
            send_frame(len, 1'b0, $urandom_range(1, int'(len) + 3), 6);
        end
        else if (r < 95)
        begin
            k = $urandom_range(1, 6);
            repeat (k) send_byte(8'($urandom));
        end
        else
        begin
            k = $urandom_range(1, 8);
            repeat (k) send_tick();
        end
        if ($urandom_range(0, 29) == 0)
            wait_results_drained();
    endtask

    task automatic test_random_traffic();
        int unsigned target;
        for (int p = 0; p < 5; p++)
        begin
            case (p)
                0:       set_timeouts(16'($urandom_range(0, 6)), 8'($urandom_range(0, 30)));
                1:       set_timeouts(16'hFFFF, 8'hFF);
                2:       set_timeouts(16'h0000, 8'h00);
                3:       set_timeouts(16'($urandom), 8'($urandom));
                default: set_timeouts(16'd2, 8'd5);
            endcase
            idle_on = (p != 3);
            target = items_accepted + 100;
            while (items_accepted < target)
                send_random_burst();
        end
        idle_on = 1'b1;
    endtask

    initial
    begin
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        test_directed_frames();
        test_timeouts();
        test_header_timeout_wide();
        test_max_payload();
        test_random_traffic();

        in_valid <= 1'b0;
        for (int i = 0; i < 20000 && deframer_out_q.size() != 0; i++)
            @(negedge clk);
        repeat (8) @(negedge clk);
        if (deframer_out_q.size() != 0)
        begin
            $error("%0d expected results never arrived", deframer_out_q.size());
            fail_count++;
        end
        if (fail_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
